@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define NSBM_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// An antecedent that, when true, requires the consequent in the same cycle.
`define NSBM_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

@@ design/nsbm_pkg.sv @@
// Package with the shared constants and types of the spare block mapper.
package nsbm_pkg;

   // Table geometry.
   localparam int TableDepth = 4096;
   localparam int AddrWidth  = $clog2(TableDepth);

   // Item operations.
   localparam logic OpScan   = 1'b0;
   localparam logic OpLookup = 1'b1;

   // Configuration register indexes.
   localparam logic CsrIdxBlockLog2 = 1'b0;
   localparam logic CsrIdxScanLimit = 1'b1;

   // Result status codes.
   localparam logic [2:0] StMapA       = 3'd0;
   localparam logic [2:0] StMapB       = 3'd1;
   localparam logic [2:0] StMapBDiff   = 3'd2;
   localparam logic [2:0] StBad        = 3'd3;
   localparam logic [2:0] StUnprog     = 3'd4;
   localparam logic [2:0] StIgnored    = 3'd5;
   localparam logic [2:0] StFound      = 3'd6;
   localparam logic [2:0] StUnmapped   = 3'd7;

   // Marker values.
   localparam logic [7:0]  ByteErased = 8'hFF;
   localparam logic [15:0] BlockNone  = 16'hFFFF;
   localparam logic [15:0] BlockBad   = 16'hFFFE;

   // Outcome of classifying one scan item.
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] logical;
      logic        map_en;
   } cls_type;

endpackage

@@ design/nsbm_classify.sv @@
// Classifier that decodes the spare bytes of one scan item.
module nsbm_classify (
   input  logic [15:0]          phys_block,
   input  logic [7:0]           spare_b0,
   input  logic [7:0]           spare_b1,
   input  logic [7:0]           spare_b2,
   input  logic [7:0]           spare_b3,
   input  logic [7:0]           spare_b4,
   input  logic [7:0]           spare_b5,
   input  logic [3:0]           block_count_log2,
   input  logic [15:0]          scan_limit,
   output nsbm_pkg::cls_type    cls
);
   import nsbm_pkg::*;

   logic [15:0] mask;
   logic        ignored;
   logic        copy_diff;

   // Logical numbers are reduced modulo the block count by masking.
   assign mask      = ~(16'hFFFF << block_count_log2);
   assign ignored   = (phys_block == 16'd0) || (phys_block >= scan_limit);
   assign copy_diff = (spare_b4 != spare_b2) || (spare_b5 != spare_b3);

   // Rules in order of priority.
   always_comb begin
      cls.status  = StIgnored;
      cls.logical = BlockNone;
      cls.map_en  = 1'b0;
      if (ignored) begin
         cls.status = StIgnored;
      end else if (spare_b0 != ByteErased) begin
         cls.status  = StBad;
         cls.logical = BlockBad;
      end else if (spare_b1 != ByteErased) begin
         cls.status  = StMapA;
         cls.logical = {spare_b1, spare_b2} & mask;
         cls.map_en  = 1'b1;
      end else if (spare_b2 == ByteErased && spare_b3 == ByteErased) begin
         cls.status = StUnprog;
      end else begin
         cls.status  = copy_diff ? StMapBDiff : StMapB;
         cls.logical = {spare_b2, spare_b3} & mask;
         cls.map_en  = 1'b1;
      end
   end

endmodule

@@ design/nsbm_map_mem.sv @@
// Block map memory with its clearing sweep after reset.
module nsbm_map_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [nsbm_pkg::AddrWidth-1:0] wr_addr,
   input  logic [15:0]                   wr_data,
   input  logic                          rd_en,
   input  logic [nsbm_pkg::AddrWidth-1:0] rd_addr,
   output logic [15:0]                   rd_data,
   output logic                          clearing
);
   import nsbm_pkg::*;

   logic [15:0]          mem [TableDepth];
   logic [AddrWidth-1:0] clear_idx_ff;
   logic [AddrWidth-1:0] clear_idx_in;
   logic                 clearing_ff;
   logic                 clearing_in;
   logic [15:0]          rd_data_ff;

   // The sweep writes the empty marker into one entry each cycle.
   assign clear_idx_in = clear_idx_ff + AddrWidth'(1);
   assign clearing_in  = clearing_ff && (clear_idx_ff != AddrWidth'(TableDepth - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_idx_ff <= '0;
      end else if (clearing_ff) begin
         clearing_ff  <= clearing_in;
         clear_idx_ff <= clear_idx_in;
      end
   end

   // Single write port, shared by the sweep and the scan items.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clear_idx_ff] <= BlockNone;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

@@ design/nand_spare_block_mapper.sv @@
// Top level of the spare block mapper: item pipeline, map memory and registers.
//
//  Channel  Handshake         Ports
//  -------  ----------------  ------------------------------------------------
//  request  start & !busy     req_op, req_phys_block, req_spare_b0..5,
//                             req_lookup_block
//  result   rsp_valid strobe  rsp_status, rsp_logical_out, rsp_physical_out,
//                             rsp_lowest_logical
//  config   csr_write_en      csr_index, csr_wdata
//
// One item is accepted per cycle while busy is low; each result passes through
// the input register, the map memory read register and the result register.
// After reset, busy stays high while the map memory is swept to the empty
// marker one entry a cycle; configuration writes are taken meanwhile.
// The receiver cannot stall: every result is shown for exactly one cycle.
module nand_spare_block_mapper (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [15:0] req_phys_block,
   input  logic [7:0]  req_spare_b0,
   input  logic [7:0]  req_spare_b1,
   input  logic [7:0]  req_spare_b2,
   input  logic [7:0]  req_spare_b3,
   input  logic [7:0]  req_spare_b4,
   input  logic [7:0]  req_spare_b5,
   input  logic [15:0] req_lookup_block,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_logical_out,
   output logic [15:0] rsp_physical_out,
   output logic [15:0] rsp_lowest_logical,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import nsbm_pkg::*;

   // Configuration registers.
   logic [3:0]  block_count_log2_ff;
   logic [15:0] scan_limit_ff;

   // Input register.
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic        s1_op_ff;
   logic [15:0] s1_phys_ff;
   logic [7:0]  s1_b0_ff, s1_b1_ff, s1_b2_ff, s1_b3_ff, s1_b4_ff, s1_b5_ff;
   logic [15:0] s1_look_ff;

   // Middle stage, alongside the memory read register.
   logic        s2_valid_ff;
   logic        s2_op_ff;
   logic [2:0]  s2_status_ff;
   logic [15:0] s2_logical_ff;
   logic [15:0] s2_phys_ff;
   logic        s2_in_range_ff;
   logic [15:0] s2_lowest_ff;

   // Result register.
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [2:0]  rsp_status_in;
   logic [15:0] rsp_logical_ff;
   logic [15:0] rsp_phys_ff;
   logic [15:0] rsp_phys_in;
   logic [15:0] rsp_lowest_ff;

   logic [15:0] min_logical_ff;
   logic [15:0] min_logical_in;

   cls_type     cls;
   logic        scan_item;
   logic        map_in_range;
   logic        wr_en;
   logic        rd_en;
   logic [15:0] rd_data;
   logic        clearing;
   logic        look_in_range;
   logic        found;

   // Items are refused during reset and the clearing sweep.
   assign busy        = reset || clearing;
   assign s1_valid_in = start && !busy;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_log2_ff <= 4'd12;
         scan_limit_ff       <= 16'd4096;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CsrIdxBlockLog2: block_count_log2_ff <= csr_wdata[3:0];
            CsrIdxScanLimit: scan_limit_ff       <= csr_wdata;
            default:         scan_limit_ff       <= scan_limit_ff;
         endcase
      end
   end

   // Input register captures an accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_op_ff   <= req_op;
         s1_phys_ff <= req_phys_block;
         s1_b0_ff   <= req_spare_b0;
         s1_b1_ff   <= req_spare_b1;
         s1_b2_ff   <= req_spare_b2;
         s1_b3_ff   <= req_spare_b3;
         s1_b4_ff   <= req_spare_b4;
         s1_b5_ff   <= req_spare_b5;
         s1_look_ff <= req_lookup_block;
      end
   end

   nsbm_classify u_classify (
      .phys_block       (s1_phys_ff),
      .spare_b0         (s1_b0_ff),
      .spare_b1         (s1_b1_ff),
      .spare_b2         (s1_b2_ff),
      .spare_b3         (s1_b3_ff),
      .spare_b4         (s1_b4_ff),
      .spare_b5         (s1_b5_ff),
      .block_count_log2 (block_count_log2_ff),
      .scan_limit       (scan_limit_ff),
      .cls              (cls)
   );

   // Table write for a mapped scan item, table read for a lookup item.
   assign scan_item     = s1_valid_ff && (s1_op_ff == OpScan);
   assign map_in_range  = {1'b0, cls.logical} < 17'(TableDepth);
   assign wr_en         = scan_item && cls.map_en && map_in_range;
   assign rd_en         = s1_valid_ff && (s1_op_ff == OpLookup);
   assign look_in_range = {1'b0, s1_look_ff} < 17'(TableDepth);

   nsbm_map_mem u_map_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (cls.logical[AddrWidth-1:0]),
      .wr_data  (s1_phys_ff),
      .rd_en    (rd_en),
      .rd_addr  (s1_look_ff[AddrWidth-1:0]),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

   // Lowest logical number mapped so far.
   always_comb begin
      min_logical_in = min_logical_ff;
      if (scan_item && cls.map_en && (cls.logical < min_logical_ff)) begin
         min_logical_in = cls.logical;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_logical_ff <= BlockNone;
      end else begin
         min_logical_ff <= min_logical_in;
      end
   end

   // Middle stage holds the scan outcome while the table read completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_op_ff       <= s1_op_ff;
         s2_status_ff   <= cls.status;
         s2_logical_ff  <= (s1_op_ff == OpLookup) ? s1_look_ff : cls.logical;
         s2_phys_ff     <= (cls.map_en && map_in_range) ? s1_phys_ff : BlockNone;
         s2_in_range_ff <= look_in_range;
         s2_lowest_ff   <= min_logical_in;
      end
   end

   // Lookup outcome from the registered table data.
   assign found = s2_in_range_ff && (rd_data != BlockNone);

   always_comb begin
      if (s2_op_ff == OpLookup) begin
         rsp_status_in = found ? StFound : StUnmapped;
         rsp_phys_in   = found ? rd_data : BlockNone;
      end else begin
         rsp_status_in = s2_status_ff;
         rsp_phys_in   = s2_phys_ff;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_logical_ff <= s2_logical_ff;
         rsp_phys_ff    <= rsp_phys_in;
         rsp_lowest_ff  <= s2_lowest_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_logical_out    = rsp_logical_ff;
   assign rsp_physical_out   = rsp_phys_ff;
   assign rsp_lowest_logical = rsp_lowest_ff;

endmodule

@@ design/nsbm_checker.sv @@
// Port checker for the spare block mapper and its binding to the top level.
`include "assert_macros.svh"

module nsbm_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_logical_out,
   input logic [15:0] rsp_physical_out,
   input logic [15:0] rsp_lowest_logical
);
   import nsbm_pkg::*;

   logic mapped_rsp;
   logic found_rsp;

   assign mapped_rsp = rsp_valid && (rsp_status == StMapA || rsp_status == StMapB ||
                                     rsp_status == StMapBDiff);
   assign found_rsp  = rsp_valid && (rsp_status == StFound);

   // Every accepted item yields a result.
   `NSBM_ASSERT_ALWAYS(a_item_gives_result, (start && !busy) |-> ##3 rsp_valid)

   // No result appears without an item accepted before it.
   `NSBM_ASSERT_IMPLIES(a_no_spurious_result, rsp_valid, $past(start && !busy, 3))

   // The lowest logical number never rises between back-to-back results.
   `NSBM_ASSERT_IMPLIES(a_lowest_monotonic, rsp_valid && $past(rsp_valid),
                        rsp_lowest_logical <= $past(rsp_lowest_logical))

   // A mapped block is never below the lowest logical number reported with it.
   `NSBM_ASSERT_IMPLIES(a_lowest_covers_map, mapped_rsp, rsp_lowest_logical <= rsp_logical_out)

   // A found lookup always carries a real physical block.
   `NSBM_ASSERT_IMPLIES(a_found_has_block, found_rsp, rsp_physical_out != BlockNone)

endmodule

bind nand_spare_block_mapper nsbm_checker u_nsbm_checker (.*);
